FILE: design/mfe_pkg.sv
// ============================================================================
// mfe_pkg: shared types and constants for the motion feature extractor
// Register indexes, field widths and the operation codes of the shared unit.
// ============================================================================
package mfe_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] REG_MOVE_THR  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_STAY_LIM  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_GRAV_REF  = 2'd2;

    localparam logic [14:0] MOVE_THR_RST = 15'd128;
    localparam logic [15:0] STAY_LIM_RST = 16'd100;
    localparam logic [14:0] GRAV_REF_RST = 15'd2509;

    // operations of the shared divide / root unit
    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] num;
        logic [63:0] den;
    } t_unit_cmd;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_unit_rsp;

endpackage

FILE: design/mfe_divsqrt.sv
// ============================================================================
// mfe_divsqrt: shared iterative divide / square-root unit
// Restoring divide, one quotient bit per cycle; digit-by-digit
// integer root, one result bit per cycle.
// ============================================================================
module mfe_divsqrt
    import mfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_cmd i_cmd,
    output t_unit_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic        r_op, n_op;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_a, n_a;      // dividend shift / radicand
    logic [63:0] r_q, n_q;      // quotient / root
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_den, n_den;
    logic        r_done, n_done;

    logic [64:0] div_trial;
    logic [65:0] sq_rem;
    logic [65:0] sq_trial;

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_done = 1'b0;
        div_trial = {r_rem, r_a[63]} - {1'b0, r_den};
        sq_rem    = {r_rem, r_a[63:62]};
        sq_trial  = sq_rem - {r_q, 2'b01};
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_op   = i_cmd.op;
            n_a    = i_cmd.num;
            n_den  = i_cmd.den;
            n_q    = '0;
            n_rem  = '0;
            n_cnt  = (i_cmd.op == OP_SQRT) ? 7'd32 : 7'd64;
        end else if (r_busy) begin
            if (r_op == OP_DIV) begin
                n_a = {r_a[62:0], 1'b0};
                if (!div_trial[64]) begin
                    n_rem = div_trial[63:0];
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = {r_rem[62:0], r_a[63]};
                    n_q   = {r_q[62:0], 1'b0};
                end
            end else begin
                n_a = {r_a[61:0], 2'b00};
                if (!sq_trial[65]) begin
                    n_rem = sq_trial[63:0];
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = sq_rem[63:0];
                    n_q   = {r_q[62:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_DIV;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_a   <= n_a;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_q;

endmodule

FILE: design/motion_feature_extractor_core.sv
// ============================================================================
// motion_feature_extractor_core: accelerometer motion feature extractor
// Keeps a reference sample and stillness state; emits the sample, the unit
// direction of its difference and its absolute magnitude deviation from gravity.
// ============================================================================
// Paths: a restart or first sample goes straight to the output; an item with no
//   feature vector or with stay squares the difference and decides; a vector with
//   zero difference takes one root, a full vector three divides and four roots.
// Flow: a new item is taken only once the last result has moved into the output
//   register; a stalled receiver holding the output register delays the next item.
// Reset: synchronous, active low; clears all kept state and restores the
//   register reset values. The output register may hold an item while the
//   next is taken.
module motion_feature_extractor_core
    import mfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  logic [47:0] s_axis_tdata,
    // tuser: restart
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, gravity_dev (16 each)
    output logic [111:0] m_axis_tdata,
    // tuser: valid_res[0], stay[1]
    output logic [1:0]  m_axis_tuser
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_DEC  = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_DSQ  = 4'd4;
    localparam logic [3:0] ST_MAG  = 4'd5;
    localparam logic [3:0] ST_OUT  = 4'd6;
    localparam logic [3:0] ST_WAIT = 4'd7;
    localparam logic [3:0] ST_MSQ  = 4'd8;

    logic [3:0]  r_st;
    logic [14:0] r_thr;
    logic [15:0] r_lim;
    logic [14:0] r_grav;

    logic signed [15:0] r_ref_x, r_ref_y, r_ref_z;
    logic        r_have_ref, r_moved, r_stay;
    logic [15:0] r_still;

    logic signed [15:0] r_x, r_y, r_z;
    logic signed [16:0] r_d [3];
    logic [33:0] r_sq [3];     // squared difference components, one per axis
    logic [1:0]  r_k;          // axis index of the divide / root passes
    logic [1:0]  r_sqk;
    logic [35:0] r_s;
    logic [35:0] r_p;
    logic [15:0] r_u [3];
    logic        r_sent;
    // quotient for the root pass is captured here
    logic [63:0] r_quo;

    // result being built, moved into the output register when it is free
    logic [111:0] r_rdata;
    logic [1:0]  r_ruser;

    logic        r_ov;
    logic [111:0] r_odata;
    logic [1:0]  r_ouser;

    t_unit_cmd   cmd;
    t_unit_rsp   rsp;

    mfe_divsqrt u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_rsp  (rsp)
    );

    // one multiplier shared over the squaring passes
    logic signed [16:0] sq_op;
    logic [16:0]        sq_abs;
    logic [33:0]        sq_val;
    always_comb begin
        sq_op  = (r_st == ST_MSQ) ?
                 ((r_sqk == 2'd0) ? 17'(r_x) : (r_sqk == 2'd1) ? 17'(r_y) : 17'(r_z)) :
                 r_d[r_sqk];
        sq_abs = sq_op[16] ? 17'(-sq_op) : sq_op;
        sq_val = 34'(sq_abs) * 34'(sq_abs);
    end

    logic [29:0] thr_sq;
    assign thr_sq = 30'(r_thr) * 30'(r_thr);

    logic        still_now;
    logic [15:0] still_nx;
    assign still_now = r_s < 36'(thr_sq);
    assign still_nx  = still_now ? ((r_still != 16'hFFFF) ? r_still + 16'd1 : r_still)
                                 : 16'd0;

    logic signed [16:0] dk;
    logic [16:0]        qk;
    assign dk = r_d[r_k];
    assign qk = 17'((rsp.res[16:0] + 17'd1) >> 1);

    logic [16:0] mag;
    logic signed [17:0] dev;
    assign mag = 17'((rsp.res[17:0] + 18'd1) >> 1);
    assign dev = 18'(mag) - 18'(r_grav);

    logic out_free;
    assign out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_st == ST_IDLE);

    always_comb begin
        cmd.start = 1'b0;
        cmd.op    = OP_DIV;
        cmd.num   = '0;
        cmd.den   = '0;
        if (r_st == ST_DIV && !r_sent) begin
            cmd.start = 1'b1;
            cmd.num   = {r_sq[r_k], 30'd0};
            cmd.den   = 64'(r_s);
        end else if (r_st == ST_DSQ && !r_sent) begin
            cmd.start = 1'b1;
            cmd.op    = OP_SQRT;
            cmd.num   = r_quo;
        end else if (r_st == ST_MAG && !r_sent) begin
            cmd.start = 1'b1;
            cmd.op    = OP_SQRT;
            cmd.num   = 64'({r_p, 2'b00});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_thr <= MOVE_THR_RST;
            r_lim <= STAY_LIM_RST;
            r_grav <= GRAV_REF_RST;
            r_have_ref <= 1'b0;
            r_moved <= 1'b0;
            r_stay <= 1'b0;
            r_still <= '0;
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_ref_z <= '0;
            r_ov <= 1'b0;
            r_sent <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MOVE_THR: r_thr  <= i_cfg_data[14:0];
                    REG_STAY_LIM: r_lim  <= i_cfg_data;
                    REG_GRAV_REF: r_grav <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            r_ov <= (r_st == ST_WAIT && out_free) ? 1'b1 : (r_ov && !m_axis_tready);
            case (r_st)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_x <= s_axis_tdata[15:0];
                        r_y <= s_axis_tdata[31:16];
                        r_z <= s_axis_tdata[47:32];
                        r_d[0] <= 17'(signed'(s_axis_tdata[15:0])) - 17'(r_ref_x);
                        r_d[1] <= 17'(signed'(s_axis_tdata[31:16])) - 17'(r_ref_y);
                        r_d[2] <= 17'(signed'(s_axis_tdata[47:32])) - 17'(r_ref_z);
                        r_sqk <= 2'd0;
                        r_rdata <= '0;
                        if (s_axis_tuser) begin
                            r_have_ref <= 1'b0;
                            r_moved <= 1'b0;
                            r_stay <= 1'b0;
                            r_still <= '0;
                            r_ref_x <= '0;
                            r_ref_y <= '0;
                            r_ref_z <= '0;
                            r_ruser <= 2'b00;
                            r_st <= ST_WAIT;
                        end else if (!r_have_ref) begin
                            r_have_ref <= 1'b1;
                            r_ref_x <= s_axis_tdata[15:0];
                            r_ref_y <= s_axis_tdata[31:16];
                            r_ref_z <= s_axis_tdata[47:32];
                            r_ruser <= {r_stay, 1'b0};
                            r_st <= ST_WAIT;
                        end else begin
                            r_st <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    r_sq[r_sqk] <= sq_val;
                    r_sqk <= r_sqk + 2'd1;
                    if (r_sqk == 2'd2) begin
                        r_s <= 36'(r_sq[0]) + 36'(r_sq[1]) + 36'(sq_val);
                        r_st <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_still <= still_nx;
                    if (!still_now) begin
                        r_moved <= 1'b1;
                        r_stay <= 1'b0;
                    end
                    r_sqk <= 2'd0;
                    r_k <= 2'd0;
                    r_u[0] <= '0;
                    r_u[1] <= '0;
                    r_u[2] <= '0;
                    if (!r_moved && still_now) begin
                        r_ruser <= {r_stay, 1'b0};
                        r_st <= ST_WAIT;
                    end else if (still_now && still_nx > r_lim) begin
                        r_stay <= 1'b1;
                        r_ruser <= 2'b10;
                        r_st <= ST_WAIT;
                    end else begin
                        r_st <= ST_MSQ;
                    end
                end
                ST_MSQ: begin
                    // sample magnitude squared, accumulated axis by axis
                    r_p <= (r_sqk == 2'd0) ? 36'(sq_val) : r_p + 36'(sq_val);
                    r_sqk <= r_sqk + 2'd1;
                    if (r_sqk == 2'd2) r_st <= (r_s == '0) ? ST_MAG : ST_DIV;
                end
                ST_DIV: begin
                    if (rsp.done && r_sent) begin
                        r_quo <= rsp.res;
                        r_sent <= 1'b0;
                        r_st <= ST_DSQ;
                    end else begin
                        r_sent <= 1'b1;
                    end
                end
                ST_DSQ: begin
                    if (rsp.done && r_sent) begin
                        r_u[r_k] <= dk[16] ? 16'(-qk) : 16'(qk);
                        r_sent <= 1'b0;
                        if (r_k == 2'd2) begin
                            r_st <= ST_MAG;
                        end else begin
                            r_k <= r_k + 2'd1;
                            r_st <= ST_DIV;
                        end
                    end else begin
                        r_sent <= 1'b1;
                    end
                end
                ST_MAG: begin
                    if (rsp.done && r_sent) begin
                        r_sent <= 1'b0;
                        r_rdata <= {16'(dev[17] ? -dev : dev), r_u[2], r_u[1], r_u[0],
                                    r_z, r_y, r_x};
                        r_ruser <= {r_stay, 1'b1};
                        r_ref_x <= r_x;
                        r_ref_y <= r_y;
                        r_ref_z <= r_z;
                        r_st <= ST_WAIT;
                    end else begin
                        r_sent <= 1'b1;
                    end
                end
                ST_WAIT: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_odata <= r_rdata;
                        r_ouser <= r_ruser;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule
